/* sv/tnrn_pkg.sv */
// shared constants, types and the terminal name table for the telnet receive negotiator
package tnrn_pkg;

    localparam int TERM_NAME_LEN = 15;
    localparam int OPTION_COUNT  = 256;
    localparam int OPT_W         = $clog2(OPTION_COUNT);
    localparam int ENTRY_W       = 8;
    localparam int TT_LAST       = TERM_NAME_LEN + 5;
    localparam int TT_IDX_W      = $clog2(TT_LAST + 1);
    localparam int NAME_IDX_W    = 6;

    localparam logic [319:0] TERM_NAME_STR = "VT100-COMPATIBLE-TERMINAL-REFERENCE-NAME";

    localparam logic [7:0] C_IAC  = 8'hFF;
    localparam logic [7:0] C_DONT = 8'd254;
    localparam logic [7:0] C_DO   = 8'd253;
    localparam logic [7:0] C_WONT = 8'd252;
    localparam logic [7:0] C_WILL = 8'd251;
    localparam logic [7:0] C_SB   = 8'd250;
    localparam logic [7:0] C_SE   = 8'd240;
    localparam logic [7:0] C_EOR  = 8'd239;

    localparam logic [7:0] OPT_BINARY = 8'd0;
    localparam logic [7:0] OPT_ECHO   = 8'd1;
    localparam logic [7:0] OPT_SGA    = 8'd3;
    localparam logic [7:0] OPT_TTYPE  = 8'd24;
    localparam logic [7:0] OPT_EOR    = 8'd25;
    localparam logic [7:0] OPT_NAWS   = 8'd31;

    localparam logic [7:0] QUAL_IS   = 8'd0;
    localparam logic [7:0] QUAL_SEND = 8'd1;

    localparam logic [1:0] MARK_NONE = 2'd0;
    localparam logic [1:0] MARK_POS  = 2'd1;
    localparam logic [1:0] MARK_NEG  = 2'd2;

    localparam logic [1:0] DEST_APP  = 2'd0;
    localparam logic [1:0] DEST_PEER = 2'd1;
    localparam logic [1:0] DEST_ECHO = 2'd2;
    localparam logic [1:0] DEST_EOR  = 2'd3;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic        single;
        logic [1:0]  single_dest;
        logic [7:0]  single_byte;
        logic        ttype;
        logic        pre_en;
        logic        pre_val;
        logic        cmd_en;
        logic [7:0]  verb;
        logic [7:0]  opt;
        logic        post_en;
        logic        post_val;
        logic        naws_en;
        logic [15:0] width;
        logic [15:0] height;
    } job_t;

    function automatic logic [7:0] term_char(input logic [NAME_IDX_W-1:0] idx);
        term_char = TERM_NAME_STR[8*(39 - int'(idx)) +: 8];
    endfunction

endpackage

/* sv/tnrn_ram.sv */
// generic single-write, single-read ram with registered read data
module tnrn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* sv/tnrn_parser.sv */
// receive byte parser with option table read-modify-write
module tnrn_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    input  logic [15:0]        window_width,
    input  logic [15:0]        window_height,
    input  logic               job_free,
    output logic               job_load,
    output tnrn_pkg::job_t     job
);
    typedef enum logic [3:0] {
        ST_DATA      = 4'd0,
        ST_IAC       = 4'd1,
        ST_WILL      = 4'd2,
        ST_WONT      = 4'd3,
        ST_DO        = 4'd4,
        ST_DONT      = 4'd5,
        ST_SB        = 4'd6,
        ST_SBDATA    = 4'd7,
        ST_SBIAC     = 4'd8,
        ST_SBDATAIAC = 4'd9
    } pstate_t;

    pstate_t     st_reg, st_next;
    logic        v1_reg;
    logic [7:0]  b_reg;
    logic [7:0]  sub_opt_reg, sub_opt_next;
    logic [7:0]  sub_first_reg, sub_first_next;
    logic        sub_has_reg, sub_has_next;
    logic [15:0] lw_reg, lw_next;
    logic [15:0] lh_reg, lh_next;
    logic        size_ok_reg, size_ok_next;
    logic [tnrn_pkg::OPTION_COUNT-1:0] valid_reg;
    logic        fwd_hit_reg;
    logic [tnrn_pkg::ENTRY_W-1:0] fwd_data_reg;

    logic        accept, fire, any, wr_en, finish;
    logic [tnrn_pkg::ENTRY_W-1:0] ram_rdata, entry, entry_new;
    logic [1:0]  pdo, pwill, sdo, swill, reply;

    assign accept = s_valid && s_ready;
    assign fire   = v1_reg && (job_free || !any);
    assign s_ready = !v1_reg || fire;
    assign job_load = fire && any;

    tnrn_ram #(.WIDTH(tnrn_pkg::ENTRY_W), .DEPTH(tnrn_pkg::OPTION_COUNT)) u_table (
        .aclk  (aclk),
        .we    (fire && wr_en),
        .waddr (b_reg),
        .wdata (entry_new),
        .re    (accept),
        .raddr (s_rx_byte),
        .rdata (ram_rdata)
    );

    assign entry = fwd_hit_reg ? fwd_data_reg
                 : (valid_reg[b_reg] ? ram_rdata : '0);
    assign pdo   = entry[7:6];
    assign pwill = entry[5:4];
    assign sdo   = entry[3:2];
    assign swill = entry[1:0];

    always_comb begin
        st_next        = st_reg;
        sub_opt_next   = sub_opt_reg;
        sub_first_next = sub_first_reg;
        sub_has_next   = sub_has_reg;
        lw_next        = lw_reg;
        lh_next        = lh_reg;
        size_ok_next   = size_ok_reg;
        job            = '0;
        job.opt        = b_reg;
        job.width      = window_width;
        job.height     = window_height;
        wr_en          = 1'b0;
        entry_new      = entry;
        reply          = tnrn_pkg::MARK_NEG;
        finish         = 1'b0;
        case (st_reg)
            ST_IAC: begin
                st_next = ST_DATA;
                if (b_reg == tnrn_pkg::C_IAC) begin
                    job.single      = 1'b1;
                    job.single_dest = tnrn_pkg::DEST_APP;
                    job.single_byte = tnrn_pkg::C_IAC;
                end else if (b_reg == tnrn_pkg::C_WILL) begin
                    st_next = ST_WILL;
                end else if (b_reg == tnrn_pkg::C_WONT) begin
                    st_next = ST_WONT;
                end else if (b_reg == tnrn_pkg::C_DONT) begin
                    st_next = ST_DONT;
                end else if (b_reg == tnrn_pkg::C_DO) begin
                    st_next = ST_DO;
                end else if (b_reg == tnrn_pkg::C_EOR) begin
                    job.single      = 1'b1;
                    job.single_dest = tnrn_pkg::DEST_EOR;
                end else if (b_reg == tnrn_pkg::C_SB) begin
                    st_next      = ST_SB;
                    sub_has_next = 1'b0;
                end
            end
            ST_WILL, ST_WONT: begin
                st_next     = ST_DATA;
                job.pre_en  = (b_reg == tnrn_pkg::OPT_ECHO);
                job.pre_val = (st_reg == ST_WONT);
                if (st_reg == ST_WILL && (b_reg == tnrn_pkg::OPT_ECHO
                        || b_reg == tnrn_pkg::OPT_SGA || b_reg == tnrn_pkg::OPT_EOR
                        || b_reg == tnrn_pkg::OPT_BINARY)) begin
                    reply = tnrn_pkg::MARK_POS;
                end
                if (sdo != reply || pwill != ((st_reg == ST_WILL) ?
                        tnrn_pkg::MARK_POS : tnrn_pkg::MARK_NEG)) begin
                    job.cmd_en = 1'b1;
                    job.verb   = (reply == tnrn_pkg::MARK_POS) ? tnrn_pkg::C_DO
                                                               : tnrn_pkg::C_DONT;
                    wr_en      = 1'b1;
                    entry_new[3:2] = reply;
                    entry_new[5:4] = (st_reg == ST_WILL) ? tnrn_pkg::MARK_POS
                                                         : tnrn_pkg::MARK_NEG;
                end
            end
            ST_DO, ST_DONT: begin
                st_next = ST_DATA;
                if (st_reg == ST_DO && b_reg == tnrn_pkg::OPT_NAWS) begin
                    wr_en          = 1'b1;
                    entry_new[7:6] = tnrn_pkg::MARK_POS;
                    entry_new[1:0] = tnrn_pkg::MARK_POS;
                    job.cmd_en     = 1'b1;
                    job.verb       = tnrn_pkg::C_WILL;
                    if (!(size_ok_reg && lw_reg == window_width
                            && lh_reg == window_height)) begin
                        job.naws_en  = 1'b1;
                        lw_next      = window_width;
                        lh_next      = window_height;
                        size_ok_next = 1'b1;
                    end
                end else begin
                    if (st_reg == ST_DO && (b_reg == tnrn_pkg::OPT_ECHO
                            || b_reg == tnrn_pkg::OPT_SGA || b_reg == tnrn_pkg::OPT_TTYPE
                            || b_reg == tnrn_pkg::OPT_BINARY)) begin
                        reply = tnrn_pkg::MARK_POS;
                    end
                    job.post_en  = (b_reg == tnrn_pkg::OPT_ECHO);
                    job.post_val = (st_reg == ST_DO);
                    if (swill != reply || pdo != ((st_reg == ST_DO) ?
                            tnrn_pkg::MARK_POS : tnrn_pkg::MARK_NEG)) begin
                        job.cmd_en = 1'b1;
                        job.verb   = (reply == tnrn_pkg::MARK_POS) ? tnrn_pkg::C_WILL
                                                                   : tnrn_pkg::C_WONT;
                        wr_en      = 1'b1;
                        entry_new[1:0] = reply;
                        entry_new[7:6] = (st_reg == ST_DO) ? tnrn_pkg::MARK_POS
                                                           : tnrn_pkg::MARK_NEG;
                    end
                end
            end
            ST_SB: begin
                if (b_reg == tnrn_pkg::C_IAC) begin
                    st_next = ST_SBIAC;
                end else begin
                    sub_has_next = 1'b0;
                    sub_opt_next = b_reg;
                    st_next      = ST_SBDATA;
                end
            end
            ST_SBDATA: begin
                if (b_reg == tnrn_pkg::C_IAC) begin
                    st_next = ST_SBDATAIAC;
                end else if (!sub_has_reg) begin
                    sub_first_next = b_reg;
                    sub_has_next   = 1'b1;
                end
            end
            ST_SBIAC: begin
                if (b_reg == tnrn_pkg::C_IAC) begin
                    sub_has_next = 1'b0;
                    sub_opt_next = b_reg;
                    st_next      = ST_SBDATA;
                end else begin
                    st_next = ST_DATA;
                end
            end
            ST_SBDATAIAC: begin
                if (b_reg == tnrn_pkg::C_IAC) begin
                    if (!sub_has_reg) begin
                        sub_first_next = tnrn_pkg::C_IAC;
                        sub_has_next   = 1'b1;
                    end
                    st_next = ST_SBDATA;
                end else if (b_reg == tnrn_pkg::C_SE) begin
                    finish       = 1'b1;
                    sub_opt_next = '0;
                    sub_has_next = 1'b0;
                    st_next      = ST_DATA;
                end else if (b_reg == tnrn_pkg::C_SB) begin
                    finish       = 1'b1;
                    sub_has_next = 1'b0;
                    st_next      = ST_SB;
                end else begin
                    sub_opt_next = '0;
                    sub_has_next = 1'b0;
                    st_next      = ST_DATA;
                end
            end
            default: begin
                if (b_reg == tnrn_pkg::C_IAC) begin
                    st_next = ST_IAC;
                end else begin
                    st_next         = ST_DATA;
                    job.single      = 1'b1;
                    job.single_dest = tnrn_pkg::DEST_APP;
                    job.single_byte = b_reg;
                end
            end
        endcase
        job.ttype = finish && sub_opt_reg == tnrn_pkg::OPT_TTYPE && sub_has_reg
                    && sub_first_reg == tnrn_pkg::QUAL_SEND;
        any = job.single || job.ttype || job.pre_en || job.cmd_en
              || job.post_en || job.naws_en;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_DATA;
            v1_reg        <= 1'b0;
            sub_opt_reg   <= '0;
            sub_first_reg <= '0;
            sub_has_reg   <= 1'b0;
            lw_reg        <= '0;
            lh_reg        <= '0;
            size_ok_reg   <= 1'b0;
            valid_reg     <= '0;
            fwd_hit_reg   <= 1'b0;
        end else begin
            if (accept) begin
                v1_reg       <= 1'b1;
                b_reg        <= s_rx_byte;
                fwd_hit_reg  <= fire && wr_en && (b_reg == s_rx_byte);
                fwd_data_reg <= entry_new;
            end else if (fire) begin
                v1_reg <= 1'b0;
            end
            if (fire) begin
                st_reg        <= st_next;
                sub_opt_reg   <= sub_opt_next;
                sub_first_reg <= sub_first_next;
                sub_has_reg   <= sub_has_next;
                lw_reg        <= lw_next;
                lh_reg        <= lh_next;
                size_ok_reg   <= size_ok_next;
                if (wr_en) begin
                    valid_reg[b_reg] <= 1'b1;
                end
            end
        end
    end

    a_stall_holds_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> v1_reg) else $error("input stalled with empty stage");
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        job_load |-> job_free) else $error("job loaded into busy emitter");
    a_naws_sets_size: assert property (@(posedge aclk) disable iff (!aresetn)
        job_load && job.naws_en |=> size_ok_reg && lw_reg == $past(window_width))
        else $error("window size not recorded");
endmodule

/* sv/tnrn_emitter.sv */
// result sequencer that expands one job into output beats
module tnrn_emitter (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               job_load,
    input  tnrn_pkg::job_t     job,
    output logic               job_free,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_dest,
    output logic [7:0]         m_out_byte,
    output logic               m_echo_local,
    output logic               m_last
);
    typedef enum logic [3:0] {
        P_IDLE, P_SINGLE, P_PRE, P_CMD_IAC, P_CMD_VERB, P_CMD_OPT,
        P_POST, P_NAWS, P_TTYPE
    } phase_t;

    phase_t phase_reg, phase_next, first, nxt;
    tnrn_pkg::job_t job_reg;
    logic [tnrn_pkg::TT_IDX_W-1:0] idx_reg;
    logic [3:0] nidx_reg;
    logic       esc_reg, esc_next;
    logic       m_valid_reg, m_last_reg, m_echo_reg;
    logic [1:0] m_dest_reg;
    logic [7:0] m_byte_reg;

    logic       step, done, adv_n;
    logic [1:0] cur_dest;
    logic [7:0] cur_byte, sb;
    logic       cur_echo;
    logic [tnrn_pkg::NAME_IDX_W-1:0] name_idx;

    assign step = (phase_reg != P_IDLE) && (!m_valid_reg || m_ready);
    assign name_idx = tnrn_pkg::NAME_IDX_W'(idx_reg) - tnrn_pkg::NAME_IDX_W'(4);

    always_comb begin
        first = P_IDLE;
        if (job.single) first = P_SINGLE;
        else if (job.ttype) first = P_TTYPE;
        else if (job.pre_en) first = P_PRE;
        else if (job.cmd_en) first = P_CMD_IAC;
        else if (job.post_en) first = P_POST;
        else if (job.naws_en) first = P_NAWS;
    end

    always_comb begin
        cur_dest = tnrn_pkg::DEST_PEER;
        cur_byte = '0;
        cur_echo = 1'b0;
        done     = 1'b1;
        nxt      = P_IDLE;
        esc_next = esc_reg;
        adv_n    = 1'b1;
        sb       = '0;
        case (nidx_reg)
            4'd3: sb = job_reg.width[15:8];
            4'd4: sb = job_reg.width[7:0];
            4'd5: sb = job_reg.height[15:8];
            4'd6: sb = job_reg.height[7:0];
            default: sb = '0;
        endcase
        case (phase_reg)
            P_SINGLE: begin
                cur_dest = job_reg.single_dest;
                cur_byte = job_reg.single_byte;
            end
            P_PRE: begin
                cur_dest = tnrn_pkg::DEST_ECHO;
                cur_echo = job_reg.pre_val;
                nxt = job_reg.cmd_en ? P_CMD_IAC : job_reg.post_en ? P_POST
                    : job_reg.naws_en ? P_NAWS : P_IDLE;
            end
            P_CMD_IAC: begin
                cur_byte = tnrn_pkg::C_IAC;
                done = 1'b0;
                nxt = P_CMD_VERB;
            end
            P_CMD_VERB: begin
                cur_byte = job_reg.verb;
                done = 1'b0;
                nxt = P_CMD_OPT;
            end
            P_CMD_OPT: begin
                cur_byte = job_reg.opt;
                nxt = job_reg.post_en ? P_POST : job_reg.naws_en ? P_NAWS : P_IDLE;
            end
            P_POST: begin
                cur_dest = tnrn_pkg::DEST_ECHO;
                cur_echo = job_reg.post_val;
                nxt = job_reg.naws_en ? P_NAWS : P_IDLE;
            end
            P_NAWS: begin
                done = (nidx_reg == 4'd8);
                case (nidx_reg)
                    4'd0: cur_byte = tnrn_pkg::C_IAC;
                    4'd1: cur_byte = tnrn_pkg::C_SB;
                    4'd2: cur_byte = tnrn_pkg::OPT_NAWS;
                    4'd7: cur_byte = tnrn_pkg::C_IAC;
                    4'd8: cur_byte = tnrn_pkg::C_SE;
                    default: begin
                        cur_byte = sb;
                        if (sb == tnrn_pkg::C_IAC && !esc_reg) begin
                            esc_next = 1'b1;
                            adv_n    = 1'b0;
                        end else begin
                            esc_next = 1'b0;
                        end
                    end
                endcase
                if (!done) nxt = P_NAWS;
            end
            P_TTYPE: begin
                done = (idx_reg == tnrn_pkg::TT_IDX_W'(tnrn_pkg::TT_LAST));
                if (idx_reg == '0) cur_byte = tnrn_pkg::C_IAC;
                else if (idx_reg == tnrn_pkg::TT_IDX_W'(1)) cur_byte = tnrn_pkg::C_SB;
                else if (idx_reg == tnrn_pkg::TT_IDX_W'(2)) cur_byte = tnrn_pkg::OPT_TTYPE;
                else if (idx_reg == tnrn_pkg::TT_IDX_W'(3)) cur_byte = tnrn_pkg::QUAL_IS;
                else if (idx_reg == tnrn_pkg::TT_IDX_W'(tnrn_pkg::TT_LAST - 1))
                    cur_byte = tnrn_pkg::C_IAC;
                else if (done) cur_byte = tnrn_pkg::C_SE;
                else cur_byte = tnrn_pkg::term_char(name_idx);
                if (!done) nxt = P_TTYPE;
            end
            default: begin
                done = 1'b0;
                nxt  = P_IDLE;
            end
        endcase
    end

    assign job_free = (phase_reg == P_IDLE) || (step && nxt == P_IDLE && done);

    always_comb begin
        phase_next = phase_reg;
        if (job_load) phase_next = first;
        else if (step) phase_next = nxt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= P_IDLE;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
            nidx_reg    <= '0;
            esc_reg     <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            if (step) begin
                m_valid_reg <= 1'b1;
                m_dest_reg  <= cur_dest;
                m_byte_reg  <= cur_byte;
                m_echo_reg  <= cur_echo;
                m_last_reg  <= done && nxt == P_IDLE;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (job_load) begin
                job_reg  <= job;
                idx_reg  <= '0;
                nidx_reg <= '0;
                esc_reg  <= 1'b0;
            end else if (step) begin
                esc_reg <= esc_next;
                if (phase_reg == P_TTYPE) idx_reg <= idx_reg + 1'b1;
                if (phase_reg == P_NAWS && adv_n) nidx_reg <= nidx_reg + 1'b1;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_dest       = m_dest_reg;
    assign m_out_byte   = m_byte_reg;
    assign m_echo_local = m_echo_reg;
    assign m_last       = m_last_reg;

    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        job_load |-> job_free) else $error("job overwritten");
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready && !job_load |=> $stable(phase_reg))
        else $error("sequence advanced while stalled");
    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        step && m_valid_reg == 1'b0 && phase_reg == P_SINGLE && !job_load |=> phase_reg == P_IDLE)
        else $error("single result did not end job");
endmodule

/* sv/telnet_receive_negotiator_unit.sv */
// top level of the telnet receive negotiator with its configuration registers
// Usage:
//   s_ channel: one received byte per beat (s_rx_byte), valid/ready handshake.
//   m_ channel: one result per beat: m_dest (0 data, 1 to peer, 2 echo event,
//   3 end of record), m_out_byte, m_echo_local, and m_last on the final result
//   of an input byte. Bytes that cause no result (IAC, command prefixes,
//   subnegotiation payload) produce no beat.
//   APB port: window_width at 0x0, window_height at 0x4; pready always high.
//   Accepted bytes are registered in the parse stage, results in the sequencer.
//   Throughput: one byte per cycle for plain data; an option byte is held in
//   the parse stage while the result sequencer drains the previous byte's
//   results, one beat per cycle (up to 21 beats for a terminal-type reply).
//   Option tables: one 256 x 8 ram with registered read, addressed by the
//   incoming byte at accept and written back from the parse stage, with
//   forwarding for a write that coincides with the read.
//   Reset: synchronous, active low; tables read as none through per-entry
//   valid flags, no clearing pass. A stalled m_ready backs up the sequencer,
//   then the parse stage, then s_ready; nothing is dropped.
module telnet_receive_negotiator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_dest,
    output logic [7:0]  m_out_byte,
    output logic        m_echo_local,
    output logic        m_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [15:0]    width_reg, height_reg;
    logic           job_free, job_load;
    tnrn_pkg::job_t job;

    assign pready = 1'b1;
    assign prdata = {16'd0, (paddr[2] == tnrn_pkg::REG_HEIGHT) ? height_reg : width_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 16'd80;
            height_reg <= 16'd24;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == tnrn_pkg::REG_WIDTH) width_reg <= pwdata[15:0];
            else height_reg <= pwdata[15:0];
        end
    end

    tnrn_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .window_width  (width_reg),
        .window_height (height_reg),
        .job_free      (job_free),
        .job_load      (job_load),
        .job           (job)
    );

    tnrn_emitter u_emitter (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_load     (job_load),
        .job          (job),
        .job_free     (job_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_dest       (m_dest),
        .m_out_byte   (m_out_byte),
        .m_echo_local (m_echo_local),
        .m_last       (m_last)
    );
endmodule

/* sim/telnet_receive_negotiator_unit_tb.sv */
// self-checking testbench for the telnet receive negotiator: random byte streams, option model
module telnet_receive_negotiator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT   = 400000;
    localparam int SETTLE  = 12;
    localparam string TERM_ID = "VT100-COMPATIBL";
    localparam logic [15:0] SIZES [6] = '{16'd0, 16'hFFFF, 16'h00FF, 16'hFF00, 16'd132, 16'd1};

    typedef enum logic [3:0] {
        PS_DATA, PS_IAC, PS_WILL, PS_WONT, PS_DO, PS_DONT,
        PS_SB, PS_SBDATA, PS_SBIAC, PS_SBDATAIAC
    } parse_t;

    typedef struct {
        logic [1:0] dest;
        logic [7:0] data;
        logic       echo;
        logic       last;
    } beat_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_dest;
    logic [7:0]  m_out_byte;
    logic        m_echo_local;
    logic        m_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    telnet_receive_negotiator_unit uut (.*);

    // predictor state
    parse_t      pstate;
    logic [1:0]  peer_do [256];
    logic [1:0]  peer_will [256];
    logic [1:0]  sent_do [256];
    logic [1:0]  sent_will [256];
    logic [7:0]  sb_opt;
    logic [7:0]  sb_first;
    logic        sb_has;
    logic [15:0] naws_w_sent;
    logic [15:0] naws_h_sent;
    logic        naws_sent;
    logic [15:0] cfg_width;
    logic [15:0] cfg_height;

    beat_t       replies_due[$];
    beat_t       step_q[$];
    logic [7:0]  rx_pending[$];

    int cycles;
    int errors;
    int bytes_in;
    int beats_out;
    int gap_left;
    int burst_left;
    int stall_mode;
    int stall_left;

    task automatic emit(input logic [1:0] d, input logic [7:0] b, input logic e);
        beat_t r;
        r.dest = d;
        r.data = b;
        r.echo = e;
        r.last = 1'b0;
        step_q.push_back(r);
    endtask

    task automatic to_peer_esc(input logic [7:0] b);
        if (b == tnrn_pkg::C_IAC) emit(tnrn_pkg::DEST_PEER, tnrn_pkg::C_IAC, 1'b0);
        emit(tnrn_pkg::DEST_PEER, b, 1'b0);
    endtask

    task automatic cmd3(input logic [7:0] verb, input logic [7:0] opt);
        emit(tnrn_pkg::DEST_PEER, tnrn_pkg::C_IAC, 1'b0);
        emit(tnrn_pkg::DEST_PEER, verb, 1'b0);
        emit(tnrn_pkg::DEST_PEER, opt, 1'b0);
    endtask

    task automatic reply_will(input logic [7:0] opt, input logic [1:0] pm, input logic [1:0] rm);
        if (sent_do[opt] != rm || peer_will[opt] != pm) begin
            cmd3(rm == tnrn_pkg::MARK_POS ? tnrn_pkg::C_DO : tnrn_pkg::C_DONT, opt);
            sent_do[opt] = rm;
            peer_will[opt] = pm;
        end
    endtask

    task automatic reply_do(input logic [7:0] opt, input logic [1:0] pm, input logic [1:0] rm);
        if (sent_will[opt] != rm || peer_do[opt] != pm) begin
            cmd3(rm == tnrn_pkg::MARK_POS ? tnrn_pkg::C_WILL : tnrn_pkg::C_WONT, opt);
            sent_will[opt] = rm;
            peer_do[opt] = pm;
        end
    endtask

    task automatic report_size();
        if (peer_do[tnrn_pkg::OPT_NAWS] != tnrn_pkg::MARK_POS) return;
        if (naws_sent && naws_w_sent == cfg_width && naws_h_sent == cfg_height) return;
        naws_w_sent = cfg_width;
        naws_h_sent = cfg_height;
        naws_sent = 1'b1;
        emit(tnrn_pkg::DEST_PEER, tnrn_pkg::C_IAC, 1'b0);
        emit(tnrn_pkg::DEST_PEER, tnrn_pkg::C_SB, 1'b0);
        emit(tnrn_pkg::DEST_PEER, tnrn_pkg::OPT_NAWS, 1'b0);
        to_peer_esc(cfg_width[15:8]);
        to_peer_esc(cfg_width[7:0]);
        to_peer_esc(cfg_height[15:8]);
        to_peer_esc(cfg_height[7:0]);
        emit(tnrn_pkg::DEST_PEER, tnrn_pkg::C_IAC, 1'b0);
        emit(tnrn_pkg::DEST_PEER, tnrn_pkg::C_SE, 1'b0);
    endtask

    task automatic close_sub();
        if (sb_opt == tnrn_pkg::OPT_TTYPE && sb_has && sb_first == tnrn_pkg::QUAL_SEND) begin
            emit(tnrn_pkg::DEST_PEER, tnrn_pkg::C_IAC, 1'b0);
            emit(tnrn_pkg::DEST_PEER, tnrn_pkg::C_SB, 1'b0);
            emit(tnrn_pkg::DEST_PEER, tnrn_pkg::OPT_TTYPE, 1'b0);
            emit(tnrn_pkg::DEST_PEER, tnrn_pkg::QUAL_IS, 1'b0);
            for (int i = 0; i < tnrn_pkg::TERM_NAME_LEN; i++)
                emit(tnrn_pkg::DEST_PEER, TERM_ID[i], 1'b0);
            emit(tnrn_pkg::DEST_PEER, tnrn_pkg::C_IAC, 1'b0);
            emit(tnrn_pkg::DEST_PEER, tnrn_pkg::C_SE, 1'b0);
        end
    endtask

    task automatic sb_take(input logic [7:0] b);
        if (!sb_has) begin
            sb_first = b;
            sb_has = 1'b1;
        end
    endtask

    task automatic negotiate(input logic [7:0] b);
        step_q.delete();
        case (pstate)
            PS_IAC: begin
                pstate = PS_DATA;
                if (b == tnrn_pkg::C_IAC) emit(tnrn_pkg::DEST_APP, tnrn_pkg::C_IAC, 1'b0);
                else if (b == tnrn_pkg::C_WILL) pstate = PS_WILL;
                else if (b == tnrn_pkg::C_WONT) pstate = PS_WONT;
                else if (b == tnrn_pkg::C_DONT) pstate = PS_DONT;
                else if (b == tnrn_pkg::C_DO) pstate = PS_DO;
                else if (b == tnrn_pkg::C_EOR) emit(tnrn_pkg::DEST_EOR, 8'd0, 1'b0);
                else if (b == tnrn_pkg::C_SB) begin
                    pstate = PS_SB;
                    sb_has = 1'b0;
                end
            end
            PS_WILL: begin
                if (b == tnrn_pkg::OPT_ECHO) emit(tnrn_pkg::DEST_ECHO, 8'd0, 1'b0);
                if (b == tnrn_pkg::OPT_ECHO || b == tnrn_pkg::OPT_SGA ||
                    b == tnrn_pkg::OPT_EOR || b == tnrn_pkg::OPT_BINARY)
                    reply_will(b, tnrn_pkg::MARK_POS, tnrn_pkg::MARK_POS);
                else
                    reply_will(b, tnrn_pkg::MARK_POS, tnrn_pkg::MARK_NEG);
                pstate = PS_DATA;
            end
            PS_WONT: begin
                if (b == tnrn_pkg::OPT_ECHO) emit(tnrn_pkg::DEST_ECHO, 8'd0, 1'b1);
                reply_will(b, tnrn_pkg::MARK_NEG, tnrn_pkg::MARK_NEG);
                pstate = PS_DATA;
            end
            PS_DO: begin
                if (b == tnrn_pkg::OPT_NAWS) begin
                    peer_do[b] = tnrn_pkg::MARK_POS;
                    sent_will[b] = tnrn_pkg::MARK_POS;
                    cmd3(tnrn_pkg::C_WILL, b);
                    report_size();
                end else if (b == tnrn_pkg::OPT_ECHO || b == tnrn_pkg::OPT_SGA ||
                             b == tnrn_pkg::OPT_TTYPE || b == tnrn_pkg::OPT_BINARY) begin
                    reply_do(b, tnrn_pkg::MARK_POS, tnrn_pkg::MARK_POS);
                    if (b == tnrn_pkg::OPT_ECHO) emit(tnrn_pkg::DEST_ECHO, 8'd0, 1'b1);
                end else begin
                    reply_do(b, tnrn_pkg::MARK_POS, tnrn_pkg::MARK_NEG);
                end
                pstate = PS_DATA;
            end
            PS_DONT: begin
                reply_do(b, tnrn_pkg::MARK_NEG, tnrn_pkg::MARK_NEG);
                if (b == tnrn_pkg::OPT_ECHO) emit(tnrn_pkg::DEST_ECHO, 8'd0, 1'b0);
                pstate = PS_DATA;
            end
            PS_SB: begin
                if (b == tnrn_pkg::C_IAC) pstate = PS_SBIAC;
                else begin
                    sb_has = 1'b0;
                    sb_opt = b;
                    pstate = PS_SBDATA;
                end
            end
            PS_SBDATA: begin
                if (b == tnrn_pkg::C_IAC) pstate = PS_SBDATAIAC;
                else sb_take(b);
            end
            PS_SBIAC: begin
                if (b == tnrn_pkg::C_IAC) begin
                    sb_has = 1'b0;
                    sb_opt = b;
                    pstate = PS_SBDATA;
                end else pstate = PS_DATA;
            end
            PS_SBDATAIAC: begin
                if (b == tnrn_pkg::C_IAC) begin
                    sb_take(tnrn_pkg::C_IAC);
                    pstate = PS_SBDATA;
                end else if (b == tnrn_pkg::C_SE) begin
                    close_sub();
                    sb_opt = 8'd0;
                    sb_has = 1'b0;
                    pstate = PS_DATA;
                end else if (b == tnrn_pkg::C_SB) begin
                    close_sub();
                    sb_has = 1'b0;
                    pstate = PS_SB;
                end else begin
                    sb_opt = 8'd0;
                    sb_has = 1'b0;
                    pstate = PS_DATA;
                end
            end
            default: begin
                if (b == tnrn_pkg::C_IAC) pstate = PS_IAC;
                else begin
                    pstate = PS_DATA;
                    emit(tnrn_pkg::DEST_APP, b, 1'b0);
                end
            end
        endcase
        if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
        foreach (step_q[i]) replies_due.push_back(step_q[i]);
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // timeout
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout at %0t, %0d beats still due", $time, replies_due.size());
            $display("FAIL telnet_receive_negotiator_unit");
            $finish;
        end
    end

    // sender: bursts with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                negotiate(s_rx_byte);
                bytes_in++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (rx_pending.size() > 0) begin
                    s_valid <= 1'b1;
                    s_rx_byte <= rx_pending.pop_front();
                    if (burst_left > 0) burst_left--;
                    else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern and result check
    always @(posedge aclk) begin
        beat_t exp_b;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                beats_out++;
                if (replies_due.size() == 0) begin
                    errors++;
                    $display("%0t unexpected beat dest=%0d byte=%02h echo=%0b last=%0b",
                             $time, m_dest, m_out_byte, m_echo_local, m_last);
                end else begin
                    exp_b = replies_due.pop_front();
                    if (m_dest !== exp_b.dest || m_out_byte !== exp_b.data ||
                        m_echo_local !== exp_b.echo || m_last !== exp_b.last) begin
                        errors++;
                        $display("%0t mismatch: expected dest=%0d byte=%02h echo=%0b last=%0b",
                                 $time, exp_b.dest, exp_b.data, exp_b.echo, exp_b.last);
                        $display("%0t            actual dest=%0d byte=%02h echo=%0b last=%0b",
                                 $time, m_dest, m_out_byte, m_echo_local, m_last);
                    end
                end
            end
            if (stall_left > 0) stall_left--;
            else begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(5, 60);
            end
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic apb_write(input logic addr_sel, input logic [15:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= (addr_sel == tnrn_pkg::REG_HEIGHT) ? 3'd4 : 3'd0;
        pwdata <= {16'h0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr_sel == tnrn_pkg::REG_HEIGHT) cfg_height = val;
        else cfg_width = val;
    endtask

    task automatic drain();
        while (rx_pending.size() > 0 || s_valid || replies_due.size() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic push3(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
        rx_pending.push_back(a);
        rx_pending.push_back(b);
        rx_pending.push_back(c);
    endtask

    function automatic logic [7:0] pick_opt();
        logic [7:0] known [6] = '{tnrn_pkg::OPT_BINARY, tnrn_pkg::OPT_ECHO, tnrn_pkg::OPT_SGA,
                                  tnrn_pkg::OPT_TTYPE, tnrn_pkg::OPT_EOR, tnrn_pkg::OPT_NAWS};
        if ($urandom_range(0, 1)) return known[$urandom_range(0, 5)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_random(input int n);
        int start;
        logic [7:0] verbs [4] = '{tnrn_pkg::C_WILL, tnrn_pkg::C_WONT, tnrn_pkg::C_DO,
                                  tnrn_pkg::C_DONT};
        start = rx_pending.size();
        while (rx_pending.size() - start < n) begin
            case ($urandom_range(0, 11))
                0, 1, 2: rx_pending.push_back(8'($urandom_range(0, 254)));
                3: begin
                    rx_pending.push_back(tnrn_pkg::C_IAC);
                    rx_pending.push_back(tnrn_pkg::C_IAC);
                end
                4, 5, 6: push3(tnrn_pkg::C_IAC, verbs[$urandom_range(0, 3)], pick_opt());
                7: begin
                    rx_pending.push_back(tnrn_pkg::C_IAC);
                    rx_pending.push_back($urandom_range(0, 1) ? tnrn_pkg::C_EOR
                                                              : 8'($urandom_range(0, 255)));
                end
                8: begin
                    push3(tnrn_pkg::C_IAC, tnrn_pkg::C_SB, tnrn_pkg::OPT_TTYPE);
                    rx_pending.push_back($urandom_range(0, 3) ? tnrn_pkg::QUAL_SEND
                                                              : 8'($urandom_range(0, 255)));
                    rx_pending.push_back(tnrn_pkg::C_IAC);
                    rx_pending.push_back($urandom_range(0, 3) ? tnrn_pkg::C_SE : tnrn_pkg::C_SB);
                end
                9: begin
                    push3(tnrn_pkg::C_IAC, tnrn_pkg::C_SB,
                          $urandom_range(0, 1) ? tnrn_pkg::OPT_TTYPE : 8'($urandom_range(0, 255)));
                    repeat ($urandom_range(0, 4)) rx_pending.push_back(8'($urandom_range(0, 255)));
                    rx_pending.push_back(tnrn_pkg::C_IAC);
                    rx_pending.push_back(8'($urandom_range(0, 255)));
                end
                10: push3(tnrn_pkg::C_IAC, tnrn_pkg::C_DO, tnrn_pkg::OPT_NAWS);
                default: rx_pending.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_rx_byte = 8'd0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'd0;
        cycles = 0;
        errors = 0;
        bytes_in = 0;
        beats_out = 0;
        gap_left = 0;
        burst_left = 0;
        stall_mode = 0;
        stall_left = 0;
        pstate = PS_DATA;
        foreach (peer_do[i]) begin
            peer_do[i] = tnrn_pkg::MARK_NONE;
            peer_will[i] = tnrn_pkg::MARK_NONE;
            sent_do[i] = tnrn_pkg::MARK_NONE;
            sent_will[i] = tnrn_pkg::MARK_NONE;
        end
        sb_opt = 8'd0;
        sb_first = 8'd0;
        sb_has = 1'b0;
        naws_w_sent = 16'd0;
        naws_h_sent = 16'd0;
        naws_sent = 1'b0;
        cfg_width = 16'd80;
        cfg_height = 16'd24;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset sizes first, then extremes
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'h0D);
        rx_pending.push_back(8'h0A);
        rx_pending.push_back(8'hFE);
        push3(tnrn_pkg::C_IAC, tnrn_pkg::C_IAC, tnrn_pkg::C_IAC);
        push3(8'h07, tnrn_pkg::C_IAC, tnrn_pkg::C_EOR);
        push3(tnrn_pkg::C_IAC, tnrn_pkg::C_DO, tnrn_pkg::OPT_NAWS);
        push3(tnrn_pkg::C_IAC, tnrn_pkg::C_WILL, tnrn_pkg::OPT_ECHO);
        push3(tnrn_pkg::C_IAC, tnrn_pkg::C_WONT, tnrn_pkg::OPT_ECHO);
        push3(tnrn_pkg::C_IAC, tnrn_pkg::C_DO, tnrn_pkg::OPT_ECHO);
        push3(tnrn_pkg::C_IAC, tnrn_pkg::C_DONT, tnrn_pkg::OPT_ECHO);
        push3(tnrn_pkg::C_IAC, tnrn_pkg::C_WILL, 8'hFF);
        push3(tnrn_pkg::C_IAC, 8'h05, 8'h41);
        push3(tnrn_pkg::C_IAC, tnrn_pkg::C_SB, tnrn_pkg::OPT_TTYPE);
        push3(tnrn_pkg::QUAL_SEND, tnrn_pkg::C_IAC, tnrn_pkg::C_SB);
        push3(tnrn_pkg::OPT_TTYPE, tnrn_pkg::QUAL_SEND, tnrn_pkg::C_IAC);
        rx_pending.push_back(tnrn_pkg::C_SE);
        push3(tnrn_pkg::C_IAC, tnrn_pkg::C_SB, tnrn_pkg::C_IAC);
        push3(tnrn_pkg::C_IAC, 8'h01, tnrn_pkg::C_IAC);
        rx_pending.push_back(tnrn_pkg::C_SE);
        push3(tnrn_pkg::C_IAC, tnrn_pkg::C_SB, tnrn_pkg::C_IAC);
        rx_pending.push_back(8'h30);
        push3(tnrn_pkg::C_IAC, tnrn_pkg::C_SB, 8'h05);
        push3(8'h09, tnrn_pkg::C_IAC, 8'h42);
        drain();
        apb_write(tnrn_pkg::REG_WIDTH, 16'hFFFF);
        apb_write(tnrn_pkg::REG_HEIGHT, 16'hFFFF);
        push3(tnrn_pkg::C_IAC, tnrn_pkg::C_DO, tnrn_pkg::OPT_NAWS);
        push3(tnrn_pkg::C_IAC, tnrn_pkg::C_DO, tnrn_pkg::OPT_NAWS);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            apb_write(tnrn_pkg::REG_WIDTH, ph < 6 ? SIZES[ph] : 16'($urandom_range(0, 65535)));
            apb_write(tnrn_pkg::REG_HEIGHT,
                      ph < 6 ? SIZES[5 - ph] : 16'($urandom_range(0, 65535)));
            push3(tnrn_pkg::C_IAC, tnrn_pkg::C_DO, tnrn_pkg::OPT_NAWS);
            queue_random(34);
            drain();
        end

        $display("covered %0d input bytes and %0d result beats over 10 window size settings",
                 bytes_in, beats_out);
        $display("negotiation, subnegotiation, escape and random stall traffic, %0d errors",
                 errors);
        if (errors == 0) begin
            $display("PASS telnet_receive_negotiator_unit");
        end else begin
            $display("FAIL telnet_receive_negotiator_unit");
        end
        $finish;
    end

endmodule

/* telnet_receive_negotiator_unit.f */
sv/tnrn_pkg.sv
sv/tnrn_ram.sv
sv/tnrn_parser.sv
sv/tnrn_emitter.sv
sv/telnet_receive_negotiator_unit.sv
sim/telnet_receive_negotiator_unit_tb.sv
